// File: hw/rtl/rnbs_pkg.sv
// shared types, widths and codes for the row nonzero-count block splitter
`timescale 1ns / 1ps

package rnbs_pkg;

	// field and register widths
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int CFG_W           = 32;
	localparam int RATE_W          = 16;
	localparam int BLK_W           = 16;
	// a 32-bit bound times a 16-bit factor never exceeds 48 bits
	localparam int WIN_W           = CFG_W + RATE_W;
	localparam int CFG_IDX_W       = 2;

	// register reset values
	localparam logic [CFG_W-1:0]  INITIAL_BOUND_RST = CFG_W'(32);
	localparam logic [CFG_W-1:0]  MAXIMUM_BOUND_RST = CFG_W'(1024);
	localparam logic [RATE_W-1:0] GROWTH_FACTOR_RST = RATE_W'(2);
	localparam logic [BLK_W-1:0]  BLOCK_LIMIT_RST   = BLK_W'(64);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_BOUND = 2'd0,
		CFG_MAXIMUM_BOUND = 2'd1,
		CFG_GROWTH_FACTOR = 2'd2,
		CFG_BLOCK_LIMIT   = 2'd3
	} cfg_idx_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SEARCH,
		ST_DONE
	} state_t;

	// settings the window search needs
	typedef struct packed {
		logic [CFG_W-1:0]  initial_bound;
		logic [CFG_W-1:0]  maximum_bound;
		logic [RATE_W-1:0] growth_factor;
	} win_cfg_t;

endpackage

// File: hw/rtl/row_nnz_geometric_block_splitter.sv
// top level: settings, block counting sequencer and output word register
//
// channel  dir  tdata                              tuser
// s_*      in   row_count                          first_row
// m_*      out  block_number                       block_start, over_limit
// cfg_*    in   write of one setting by index      -
//
// a row that keeps its window, or is refused, goes from acceptance through
// the eval and done states to its result word; a row placed in the top window
// also passes the search state, and a row that searches below the maximum
// bound stays there while the shared window unit takes its multiply steps.
// the block returns to idle before the next row is accepted, so it takes no
// new row before the last one has reached the output register. the result
// waits in the output register while the next row is taken in; a row only
// stalls when the word before it has not left. reset restores the settings,
// empties the window and clears the block count and the refusal flag.
`timescale 1ns / 1ps

module row_nnz_geometric_block_splitter
	import rnbs_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	localparam int IN_DATA_W  = ((COUNT_WIDTH + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,    // row_count
	input  logic                 s_tuser,    // first_row
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [BLK_W-1:0]     m_tdata,    // block_number
	output logic [1:0]           m_tuser,    // block_start, over_limit
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	state_t                 state_q, state_d;
	logic [CFG_W-1:0]       initial_q;
	logic [CFG_W-1:0]       maximum_q;
	logic [RATE_W-1:0]      growth_q;
	logic [BLK_W-1:0]       limit_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   first_q;
	logic [BLK_W-1:0]       blocks_q;
	logic                   refused_q;
	logic                   start_q;
	logic                   out_valid_q;
	logic [BLK_W-1:0]       out_blocks_q;
	logic                   out_start_q;
	logic                   out_refused_q;
	win_cfg_t               win_cfg;
	logic                   win_start;
	logic                   win_busy;
	logic [WIN_W-1:0]       win_low;
	logic [WIN_W-1:0]       win_high;
	logic [WIN_W-1:0]       count_x;
	logic                   in_window;
	logic                   restart;
	logic [BLK_W:0]         next_blocks;
	logic                   over;
	logic                   search;
	logic                   out_load;

	// settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q <= INITIAL_BOUND_RST;
			maximum_q <= MAXIMUM_BOUND_RST;
			growth_q  <= GROWTH_FACTOR_RST;
			limit_q   <= BLOCK_LIMIT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_INITIAL_BOUND: initial_q <= cfg_wdata;
				CFG_MAXIMUM_BOUND: maximum_q <= cfg_wdata;
				CFG_GROWTH_FACTOR: growth_q  <= cfg_wdata[RATE_W-1:0];
				CFG_BLOCK_LIMIT:   limit_q   <= cfg_wdata[BLK_W-1:0];
				default:           ;
			endcase
		end
	end

	assign win_cfg = '{initial_bound: initial_q, maximum_bound: maximum_q,
		growth_factor: growth_q};

	// row decision against the current window
	always_comb begin
		count_x     = WIN_W'(count_q);
		in_window   = ((count_x >= win_low) && (count_x < win_high)) ||
			((count_x >= win_high) && (win_high > WIN_W'(maximum_q)));
		restart     = first_q || ((blocks_q == '0) && !refused_q);
		next_blocks = {1'b0, blocks_q} + (BLK_W + 1)'(1);
		over        = next_blocks[BLK_W] || (next_blocks > {1'b0, limit_q});
		search      = restart || (!refused_q && !in_window && !over);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_EVAL;
			ST_EVAL:   state_d = search ? ST_SEARCH : ST_DONE;
			ST_SEARCH: if (!win_busy) state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		win_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready  = 1'b1;
			ST_EVAL:   win_start = search;
			ST_SEARCH: ;
			ST_DONE:   out_load  = !out_valid_q || m_tready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// accepted row
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			count_q <= s_tdata[COUNT_WIDTH-1:0];
			first_q <= s_tuser;
		end
	end

	// block count and refusal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q  <= '0;
			refused_q <= 1'b0;
			start_q   <= 1'b0;
		end else if (state_q == ST_EVAL) begin
			if (restart) begin
				blocks_q  <= BLK_W'(1);
				refused_q <= 1'b0;
				start_q   <= 1'b1;
			end else if (!refused_q && !in_window) begin
				blocks_q  <= next_blocks[BLK_W] ? '1 : next_blocks[BLK_W-1:0];
				refused_q <= over;
				start_q   <= 1'b1;
			end else begin
				start_q   <= 1'b0;
			end
		end
	end

	rnbs_window #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (win_start),
		.count   (count_q),
		.cfg     (win_cfg),
		.busy    (win_busy),
		.win_low (win_low),
		.win_high(win_high)
	);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_blocks_q  <= blocks_q;
			out_start_q   <= start_q;
			out_refused_q <= refused_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_blocks_q;
	assign m_tuser  = {out_refused_q, out_start_q};

	// checks
	a_win_busy_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		win_busy |-> (state_q == ST_SEARCH))
		else $error("window unit busy outside search");

	a_refused_has_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata != '0))
		else $error("refusal reported with no block open");

	a_start_has_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata != '0))
		else $error("block start reported with zero block count");

endmodule

// File: hw/rtl/rnbs_window.sv
// iterative window search around one shared 32x16 multiplier
`timescale 1ns / 1ps

module rnbs_window
	import rnbs_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [COUNT_WIDTH-1:0] count,     // held stable by the sequencer during a search
	input  win_cfg_t               cfg,
	output logic                   busy,
	output logic [WIN_W-1:0]       win_low,
	output logic [WIN_W-1:0]       win_high
);

	logic              busy_q;
	logic [WIN_W-1:0]  lo_q;
	logic [WIN_W-1:0]  hi_q;
	logic [RATE_W-1:0] rate;
	logic [WIN_W-1:0]  init_x;
	logic [WIN_W-1:0]  max_x;
	logic [WIN_W-1:0]  count_x;
	logic [CFG_W-1:0]  mul_a;
	logic [WIN_W-1:0]  prod;
	logic              step;

	// clamp factor and first bound
	always_comb begin
		rate    = (cfg.growth_factor < RATE_W'(2)) ? RATE_W'(2) : cfg.growth_factor;
		init_x  = (cfg.initial_bound == '0) ? WIN_W'(1) : WIN_W'(cfg.initial_bound);
		max_x   = WIN_W'(cfg.maximum_bound);
		count_x = WIN_W'(count);
	end

	// shared multiplier: top window on start, current upper end while searching
	always_comb begin
		mul_a = busy_q ? hi_q[CFG_W-1:0] : cfg.maximum_bound;
		prod  = WIN_W'(mul_a) * WIN_W'(rate);
		step  = (count_x >= hi_q) && (hi_q <= max_x);
	end

	// one window step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			lo_q   <= '0;
			hi_q   <= '0;
		end else if (start) begin
			if (count_x < max_x) begin
				lo_q   <= '0;
				hi_q   <= init_x;
				busy_q <= 1'b1;
			end else begin
				lo_q <= max_x;
				hi_q <= prod;
			end
		end else if (busy_q) begin
			if (step) begin
				lo_q <= hi_q;
				hi_q <= prod;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign win_low  = lo_q;
	assign win_high = hi_q;

endmodule

// File: tb/sv/block_split_checker.sv
// checker for the row block splitter: predicts each result word and compares it on arrival
`timescale 1ns / 1ps

module block_split_checker
	import rnbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [31:0]          s_tdata,    // row_count
	input  logic                 s_tuser,    // first_row
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [BLK_W-1:0]     m_tdata,    // block_number
	input  logic [1:0]           m_tuser,    // block_start, over_limit
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output int                   pending,
	output int                   errors,
	output int                   checked
);

	localparam int COUNT_W = COUNT_WIDTH_DEF;

	typedef struct packed {
		logic             block_start;
		logic [BLK_W-1:0] block_number;
		logic             over_limit;
	} split_word_t;

	// shadow settings
	logic [CFG_W-1:0]  init_bound;
	logic [CFG_W-1:0]  max_bound;
	logic [RATE_W-1:0] growth;
	logic [BLK_W-1:0]  blk_limit;

	// shadow splitter state
	logic [63:0]      win_low;
	logic [63:0]      win_high;
	logic [BLK_W-1:0] blocks_open;
	logic             split_refused;

	split_word_t expected_splits[$];
	int          mismatch_count;
	int          word_count;

	// bound times factor, saturating at the top of 64 bits
	function automatic logic [63:0] scale_bound(input logic [63:0] bound, input logic [63:0] f);
		if (bound > 64'hFFFF_FFFF_FFFF_FFFF / f)
			return 64'hFFFF_FFFF_FFFF_FFFF;
		return bound * f;
	endfunction

	// geometric window search for one count
	function automatic void place_window(input logic [63:0] c);
		logic [63:0] f;
		logic [63:0] lo;
		logic [63:0] hi;
		f  = (growth < 2) ? 64'd2 : 64'(growth);
		lo = '0;
		hi = (init_bound == '0) ? 64'd1 : 64'(init_bound);
		if (c < 64'(max_bound)) begin
			while (c >= hi && hi <= 64'(max_bound)) begin
				lo = hi;
				hi = scale_bound(hi, f);
			end
		end else begin
			lo = 64'(max_bound);
			hi = scale_bound(64'(max_bound), f);
		end
		win_low  = lo;
		win_high = hi;
	endfunction

	// next result word for one row, advancing the shadow state
	function automatic split_word_t predict_split(input logic [COUNT_W-1:0] count, input logic first);
		logic [63:0]    c;
		logic           start;
		logic           fits;
		logic [BLK_W:0] next;
		c     = 64'(count);
		start = 1'b0;
		if (first || (blocks_open == '0 && !split_refused)) begin
			split_refused = 1'b0;
			blocks_open   = BLK_W'(1);
			place_window(c);
			start = 1'b1;
		end else if (!split_refused) begin
			// counts above a window that already tops the maximum stay put
			fits = (c >= win_low && c < win_high) ||
				(c >= win_high && win_high > 64'(max_bound));
			if (!fits) begin
				next  = {1'b0, blocks_open} + 1'b1;
				start = 1'b1;
				if (next[BLK_W] || next > {1'b0, blk_limit})
					split_refused = 1'b1;
				blocks_open = next[BLK_W] ? '1 : next[BLK_W-1:0];
				if (!split_refused)
					place_window(c);
			end
		end
		return '{start, blocks_open, split_refused};
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned want,
		input longint unsigned got);
		mismatch_count++;
		// keep the log short when something is badly broken
		if (mismatch_count <= 100)
			$display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $time);
	endtask

	// watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin : watch
		split_word_t want;
		if (!arst_n) begin
			init_bound    = INITIAL_BOUND_RST;
			max_bound     = MAXIMUM_BOUND_RST;
			growth        = GROWTH_FACTOR_RST;
			blk_limit     = BLOCK_LIMIT_RST;
			win_low       = '0;
			win_high      = '0;
			blocks_open   = '0;
			split_refused = 1'b0;
			expected_splits.delete();
			pending <= 0;
		end else begin
			// result word against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (expected_splits.size() == 0) begin
					report_mismatch("unexpected word, block_number", 0, m_tdata);
				end else begin
					want = expected_splits.pop_front();
					word_count++;
					if (m_tdata !== want.block_number)
						report_mismatch("block_number", want.block_number, m_tdata);
					if (m_tuser[0] !== want.block_start)
						report_mismatch("block_start", want.block_start, m_tuser[0]);
					if (m_tuser[1] !== want.over_limit)
						report_mismatch("over_limit", want.over_limit, m_tuser[1]);
				end
			end
			// accepted row word, appended behind the older predictions
			if (s_tvalid && s_tready)
				expected_splits = {expected_splits,
					predict_split(s_tdata[COUNT_W-1:0], s_tuser)};
			// setting writes take effect for later rows
			if (cfg_wen) begin
				case (cfg_idx_t'(cfg_index))
					CFG_INITIAL_BOUND: init_bound = cfg_wdata;
					CFG_MAXIMUM_BOUND: max_bound  = cfg_wdata;
					CFG_GROWTH_FACTOR: growth     = cfg_wdata[RATE_W-1:0];
					CFG_BLOCK_LIMIT:   blk_limit  = cfg_wdata[BLK_W-1:0];
					default: ;
				endcase
			end
			pending <= expected_splits.size();
		end
		errors  <= mismatch_count;
		checked <= word_count;
	end

	initial begin
		mismatch_count = 0;
		word_count     = 0;
	end

endmodule

// File: tb/sv/testbench.sv
// top of the row block splitter testbench: clock, reset, row stimulus and verdict
`timescale 1ns / 1ps

module testbench;
	import rnbs_pkg::*;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata   = '0;    // row_count
	logic                 s_tuser   = 1'b0;  // first_row
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [BLK_W-1:0]     m_tdata;           // block_number
	logic [1:0]           m_tuser;           // block_start, over_limit
	logic                 cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_INITIAL_BOUND;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	int pending;
	int errors;
	int checked;

	int tx_idle_pct = 10;
	int rx_idle_pct = 84;
	int rows_sent   = 0;
	int settings    = 0;

	// settings as last written, used to aim the row counts
	logic [CFG_W-1:0]  ib_now = INITIAL_BOUND_RST;
	logic [CFG_W-1:0]  mb_now = MAXIMUM_BOUND_RST;
	logic [RATE_W-1:0] gf_now = GROWTH_FACTOR_RST;

	row_nnz_geometric_block_splitter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	block_split_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.errors    (errors),
		.checked   (checked)
	);

	// 10 ns clock
	initial begin
		forever #5 clk = ~clk;
	end

	// result side back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// present one row word and hold it until taken
	task automatic send_row(input logic [31:0] count, input logic first);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= count;
		s_tuser  <= first;
		rows_sent++;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// let every outstanding word drain so settings can change
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write all four settings on consecutive edges
	task automatic load_settings(input logic [CFG_W-1:0] ib, input logic [CFG_W-1:0] mb,
		input logic [RATE_W-1:0] gf, input logic [BLK_W-1:0] bl);
		cfg_wen   <= 1'b1;
		cfg_index <= CFG_INITIAL_BOUND;
		cfg_wdata <= ib;
		@(posedge clk);
		cfg_index <= CFG_MAXIMUM_BOUND;
		cfg_wdata <= mb;
		@(posedge clk);
		cfg_index <= CFG_GROWTH_FACTOR;
		cfg_wdata <= CFG_W'(gf);
		@(posedge clk);
		cfg_index <= CFG_BLOCK_LIMIT;
		cfg_wdata <= CFG_W'(bl);
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		ib_now = ib;
		mb_now = mb;
		gf_now = gf;
		settings++;
	endtask

	// row counts clustered around the window edges, with some spread
	function automatic logic [31:0] pick_count();
		logic [32:0] span;
		logic [63:0] edge_val;
		int          steps;
		span     = {1'b0, mb_now} + {1'b0, mb_now} + 33'd8;
		edge_val = (ib_now == '0) ? 64'd1 : 64'(ib_now);
		steps    = $urandom_range(0, 6);
		case ($urandom_range(9)) inside
			[0:2]: return span[32] ? $urandom : $urandom_range(0, span[31:0]);
			[3:4]: return mb_now + $urandom_range(0, 4) - 2;
			5: return ib_now + $urandom_range(0, 4) - 2;
			[6:7]: begin
				repeat (steps)
					if (edge_val < 64'h1_0000_0000)
						edge_val = edge_val * ((gf_now < 2) ? 64'd2 : 64'(gf_now));
				return edge_val[31:0] + $urandom_range(0, 2) - 1;
			end
			8: return $urandom;
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	// stimulus
	initial begin : stimulus
		logic [CFG_W-1:0]  ib;
		logic [CFG_W-1:0]  mb;
		logic [RATE_W-1:0] gf;
		logic [BLK_W-1:0]  bl;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: row before any first row, long search, top window
		send_row(32'd5, 1'b0);
		send_row(32'd7, 1'b0);
		send_row(32'd32, 1'b0);
		send_row(32'd1023, 1'b0);
		send_row(32'd1024, 1'b0);
		send_row(32'hFFFF_FFFF, 1'b0);
		send_row(32'd0, 1'b1);
		send_row(32'hFFFF_FFFF, 1'b1);
		drain();

		// zero initial bound, factor below two, zero limit: refusal and frozen rows
		load_settings(32'd0, 32'd100, 16'd1, 16'd0);
		send_row(32'd3, 1'b1);
		send_row(32'd2, 1'b0);
		send_row(32'd200, 1'b0);
		send_row(32'd5, 1'b0);
		send_row(32'd3, 1'b0);
		send_row(32'd50, 1'b1);
		drain();

		// every setting at its top value
		load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_row(32'd0, 1'b1);
		send_row(32'hFFFF_FFFE, 1'b0);
		send_row(32'hFFFF_FFFF, 1'b0);
		send_row(32'd0, 1'b0);
		drain();

		// smallest bounds, factor zero, limit one
		load_settings(32'd1, 32'd1, 16'd0, 16'd1);
		send_row(32'd0, 1'b1);
		send_row(32'd1, 1'b0);
		send_row(32'd0, 1'b0);
		drain();

		// random matrices under random settings
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 3) begin
				tx_idle_pct = 84;
				rx_idle_pct = 10;
			end else if (ph == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case ($urandom_range(3))
				0: ib = $urandom_range(1, 64);
				1: ib = $urandom_range(1, 4096);
				2: ib = $urandom;
				default: ib = $urandom_range(0, 3);
			endcase
			case ($urandom_range(3))
				0: mb = $urandom_range(16, 8192);
				1: mb = ib + $urandom_range(0, 1000);
				2: mb = $urandom;
				default: mb = $urandom_range(1, 64);
			endcase
			case ($urandom_range(3))
				0: gf = RATE_W'($urandom_range(2, 4));
				1: gf = RATE_W'($urandom_range(0, 1));
				2: gf = RATE_W'($urandom_range(2, 65535));
				default: gf = RATE_W'($urandom_range(5, 16));
			endcase
			case ($urandom_range(3))
				0: bl = BLK_W'($urandom_range(0, 8));
				1: bl = BLK_W'($urandom_range(9, 40));
				2: bl = BLK_W'($urandom_range(0, 65535));
				default: bl = 16'hFFFF;
			endcase
			load_settings(ib, mb, gf, bl);
			for (int r = 0; r < 64; r++)
				send_row(pick_count(), (r == 0) || ($urandom_range(39) == 0));
			drain();
		end

		repeat (50) @(posedge clk);
		$display("summary: %0d rows sent, %0d result words checked, %0d settings loaded",
			rows_sent, checked, settings);
		$display("summary: covered refusal, frozen rows, extreme settings and both stall mixes");
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// hard stop if the run hangs
	initial begin
		#40_000_000;
		$display("timeout: %0d words still expected", pending);
		$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/rnbs_pkg.sv
hw/rtl/rnbs_window.sv
hw/rtl/row_nnz_geometric_block_splitter.sv
tb/sv/block_split_checker.sv
tb/sv/testbench.sv
